>>> sv/cfd_pkg.sv
// Shared types and constants for the CRC-16 frame deframer.
// Used by cfd_ctrl, cfd_datapath and crc16_frame_deframer_top; no dependencies.
package cfd_pkg;

  // Header-follow bytes kept for a rescan after a length rejection
  localparam int unsigned ReplayDepth = 6;
  localparam int unsigned ReplayIdxW  = $clog2(ReplayDepth);

  // Modbus CRC-16
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Fixed bytes of a frame besides the payload
  localparam logic [16:0] FrameOverhead = 17'd10;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_HEADER_FIRST,
    REG_HEADER_SECOND,
    REG_MAX_FRAME
  } reg_idx_t;

  localparam logic [7:0]  HeaderFirstRst  = 8'hAA;
  localparam logic [7:0]  HeaderSecondRst = 8'h55;
  localparam logic [15:0] MaxFrameRst     = 16'd256;

  // One result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] frame_addr;
    logic [7:0]  frame_type;
    logic [7:0]  frame_cmd;
    logic [15:0] payload_len;
    logic        crc_ok;
    logic        last;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                  use_replay;
    logic [ReplayIdxW-1:0] replay_idx;
    logic                  load_addr_lo;
    logic                  load_addr_hi;
    logic                  load_type;
    logic                  load_cmd;
    logic                  load_len_lo;
    logic                  load_len_hi;
    logic                  load_crc_lo;
    logic                  crc_init;
    logic                  crc_update;
    logic                  push_payload;
    logic                  push_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr_first_hit;
    logic hdr_second_hit;
    logic len_too_big;
    logic len_zero;
    logic last_payload;
    logic queue_full;
  } dp_stat_t;

endpackage

>>> sv/crc16_frame_deframer_top.sv
// Top level of the CRC-16 frame deframer: configuration registers, controller and datapath.
// Depends on cfd_pkg, cfd_ctrl and cfd_datapath.
//
// Receives one byte per cycle, hunts for the two-byte header, then parses address, type,
// command, length, payload and a Modbus CRC-16. Every payload byte leaves as a transaction
// with kind 0; a final transaction with kind 1 and last set carries the header fields and
// crc_ok. Throughput is one byte per cycle while in_stall is low. When a declared length
// makes the frame longer than max_frame_bytes, the six bytes after the header are
// rescanned from a six-entry buffer, one per cycle, and in_stall stays high for the
// whole rescan. Results pass through a two-entry queue, so input continues while a
// result waits; in_stall also rises when that queue is full. Registers: header_first
// at 0x0, header_second at 0x4, max_frame_bytes at 0x8.
module crc16_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] frame_addr,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_cmd,
  output logic [15:0] payload_len,
  output logic        crc_ok,
  output logic        last
);

  logic [7:0]        header_first;
  logic [7:0]        header_second;
  logic [15:0]       max_frame_bytes;
  cfd_pkg::dp_cmd_t  cmd;
  cfd_pkg::dp_stat_t stat;
  cfd_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = cfd_pkg::reg_idx_t'(paddr[3:2]);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= cfd_pkg::HeaderFirstRst;
      header_second   <= cfd_pkg::HeaderSecondRst;
      max_frame_bytes <= cfd_pkg::MaxFrameRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        cfd_pkg::REG_HEADER_FIRST:  header_first    <= pwdata[7:0];
        cfd_pkg::REG_HEADER_SECOND: header_second   <= pwdata[7:0];
        cfd_pkg::REG_MAX_FRAME:     max_frame_bytes <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (reg_idx)
      cfd_pkg::REG_HEADER_FIRST:  prdata = {24'h0, header_first};
      cfd_pkg::REG_HEADER_SECOND: prdata = {24'h0, header_second};
      cfd_pkg::REG_MAX_FRAME:     prdata = {16'h0, max_frame_bytes};
      default:                    prdata = 32'h0;
    endcase
  end

  cfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .header_first    (header_first),
    .header_second   (header_second),
    .max_frame_bytes (max_frame_bytes),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .frame_addr      (frame_addr),
    .frame_type      (frame_type),
    .frame_cmd       (frame_cmd),
    .payload_len     (payload_len),
    .crc_ok          (crc_ok),
    .last            (last)
  );

  // A replayed byte never coincides with a result push
  a_replay_no_push: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.use_replay, cmd.push_payload, cmd.push_status}))
    else $error("replay overlaps a result push");

  // Input is held off for the whole replay
  a_replay_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.use_replay |-> in_stall)
    else $error("input not stalled during replay");

  // The queue is never pushed when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_payload || cmd.push_status) |-> !stat.queue_full)
    else $error("result queue overflow");

  // A rejected length starts a replay in the next cycle
  a_reject_replays: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_len_hi && stat.len_too_big) |=> cmd.use_replay)
    else $error("rejected frame not replayed");

endmodule

>>> sv/cfd_ctrl.sv
// Parse controller of the CRC-16 frame deframer: frame phase, header hunt and replay sequencing.
// Depends on cfd_pkg; drives commands into cfd_datapath.
module cfd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfd_pkg::dp_stat_t  stat,
  output cfd_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_ADDR_LO,
    PH_ADDR_HI,
    PH_TYPE,
    PH_CMD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  phase_t                         phase, phase_next;
  logic                           seen_first, seen_first_next;
  logic                           replaying, replaying_next;
  logic [cfd_pkg::ReplayIdxW-1:0] replay_cnt, replay_cnt_next;
  logic                           step;

  // Hold off new bytes while replaying or while the result queue is full
  assign in_stall = replaying | stat.queue_full;
  assign step     = replaying | (in_valid & ~in_stall);

  // Next state and commands for the byte handled this cycle
  always_comb begin
    phase_next      = phase;
    seen_first_next = seen_first;
    replaying_next  = replaying;
    replay_cnt_next = replay_cnt;
    cmd             = '0;
    cmd.use_replay  = replaying;
    cmd.replay_idx  = replay_cnt;

    // Advance through the replay buffer
    if (replaying) begin
      replay_cnt_next = replay_cnt + 1'b1;
      if (replay_cnt == cfd_pkg::ReplayIdxW'(cfd_pkg::ReplayDepth - 1)) begin
        replaying_next = 1'b0;
      end
    end

    if (step) begin
      unique case (phase)
        PH_HUNT: begin
          if (seen_first && stat.hdr_second_hit) begin
            seen_first_next = 1'b0;
            cmd.crc_init    = 1'b1;
            phase_next      = PH_ADDR_LO;
          end else begin
            seen_first_next = stat.hdr_first_hit;
          end
        end
        PH_ADDR_LO: begin
          cmd.load_addr_lo = 1'b1;
          phase_next       = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          cmd.load_addr_hi = 1'b1;
          phase_next       = PH_TYPE;
        end
        PH_TYPE: begin
          cmd.load_type  = 1'b1;
          cmd.crc_update = 1'b1;
          phase_next     = PH_CMD;
        end
        PH_CMD: begin
          cmd.load_cmd   = 1'b1;
          cmd.crc_update = 1'b1;
          phase_next     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cmd.load_len_lo = 1'b1;
          cmd.crc_update  = 1'b1;
          phase_next      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          cmd.load_len_hi = 1'b1;
          cmd.crc_update  = 1'b1;
          if (stat.len_too_big) begin
            // Drop the header and rescan the six bytes after it
            phase_next      = PH_HUNT;
            seen_first_next = 1'b0;
            replaying_next  = 1'b1;
            replay_cnt_next = '0;
          end else if (stat.len_zero) begin
            phase_next = PH_CRC_LO;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cmd.crc_update   = 1'b1;
          cmd.push_payload = 1'b1;
          if (stat.last_payload) begin
            phase_next = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          cmd.load_crc_lo = 1'b1;
          phase_next      = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          cmd.push_status = 1'b1;
          seen_first_next = 1'b0;
          phase_next      = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      seen_first <= 1'b0;
      replaying  <= 1'b0;
      replay_cnt <= '0;
    end else begin
      phase      <= phase_next;
      seen_first <= seen_first_next;
      replaying  <= replaying_next;
      replay_cnt <= replay_cnt_next;
    end
  end

endmodule

>>> sv/cfd_datapath.sv
// Datapath of the CRC-16 frame deframer: field holds, CRC, replay buffer and result queue.
// Depends on cfd_pkg; steered by cfd_ctrl.
module cfd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        header_first,
  input  logic [7:0]        header_second,
  input  logic [15:0]       max_frame_bytes,
  input  cfd_pkg::dp_cmd_t  cmd,
  output cfd_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [7:0]        payload_byte,
  output logic [15:0]       frame_addr,
  output logic [7:0]        frame_type,
  output logic [7:0]        frame_cmd,
  output logic [15:0]       payload_len,
  output logic              crc_ok,
  output logic              last
);

  // One byte of Modbus CRC-16, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ cfd_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic [7:0]  replay_buf [cfd_pkg::ReplayDepth];
  logic [7:0]  cur_byte;
  logic [15:0] addr_hold;
  logic [7:0]  type_hold;
  logic [7:0]  cmd_hold;
  logic [15:0] length_hold;
  logic [15:0] crc_accum;
  logic [7:0]  rx_crc_low;
  logic [15:0] field_counter;
  logic [15:0] len_full;

  cfd_pkg::result_t fifo_q [2];
  cfd_pkg::result_t res_new;
  cfd_pkg::result_t res_head;
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push, pop;

  // Select the byte under work: replayed or freshly received
  assign cur_byte = cmd.use_replay ? replay_buf[cmd.replay_idx] : rx_byte;
  assign len_full = {cur_byte, length_hold[7:0]};

  // Status toward the controller
  assign stat.hdr_first_hit  = (cur_byte == header_first);
  assign stat.hdr_second_hit = (cur_byte == header_second);
  assign stat.len_too_big    = ({1'b0, len_full} + cfd_pkg::FrameOverhead)
                               > {1'b0, max_frame_bytes};
  assign stat.len_zero       = (len_full == 16'd0);
  assign stat.last_payload   = (field_counter == 16'd1);
  assign stat.queue_full     = count[1];

  // Field holds and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_hold     <= '0;
      type_hold     <= '0;
      cmd_hold      <= '0;
      length_hold   <= '0;
      crc_accum     <= cfd_pkg::CrcInit;
      rx_crc_low    <= '0;
      field_counter <= '0;
    end else begin
      if (cmd.crc_init) begin
        crc_accum     <= cfd_pkg::CrcInit;
        field_counter <= '0;
      end else if (cmd.crc_update) begin
        crc_accum <= crc_byte(crc_accum, cur_byte);
      end
      if (cmd.load_addr_lo) addr_hold <= {8'h00, cur_byte};
      if (cmd.load_addr_hi) addr_hold <= {cur_byte, addr_hold[7:0]};
      if (cmd.load_type) type_hold <= cur_byte;
      if (cmd.load_cmd) cmd_hold <= cur_byte;
      if (cmd.load_len_lo) length_hold <= {8'h00, cur_byte};
      if (cmd.load_len_hi) begin
        length_hold   <= len_full;
        field_counter <= len_full;
      end
      if (cmd.push_payload) field_counter <= field_counter - 16'd1;
      if (cmd.load_crc_lo) rx_crc_low <= cur_byte;
    end
  end

  // Keep the six header-follow bytes for a possible rescan
  always_ff @(posedge clk) begin
    if (cmd.load_addr_lo) replay_buf[0] <= cur_byte;
    if (cmd.load_addr_hi) replay_buf[1] <= cur_byte;
    if (cmd.load_type)    replay_buf[2] <= cur_byte;
    if (cmd.load_cmd)     replay_buf[3] <= cur_byte;
    if (cmd.load_len_lo)  replay_buf[4] <= cur_byte;
    if (cmd.load_len_hi)  replay_buf[5] <= cur_byte;
  end

  // Build the result transaction
  always_comb begin
    res_new.kind         = cmd.push_status;
    res_new.payload_byte = cmd.push_status ? 8'h00 : cur_byte;
    res_new.frame_addr   = addr_hold;
    res_new.frame_type   = type_hold;
    res_new.frame_cmd    = cmd_hold;
    res_new.payload_len  = length_hold;
    res_new.crc_ok       = cmd.push_status & ({cur_byte, rx_crc_low} == crc_accum);
    res_new.last         = cmd.push_status;
  end

  // Two-entry result queue
  assign push = cmd.push_payload | cmd.push_status;
  assign pop  = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push) fifo_q[wr_ptr] <= res_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign res_head     = fifo_q[rd_ptr];
  assign out_valid    = (count != 2'd0);
  assign kind         = res_head.kind;
  assign payload_byte = res_head.payload_byte;
  assign frame_addr   = res_head.frame_addr;
  assign frame_type   = res_head.frame_type;
  assign frame_cmd    = res_head.frame_cmd;
  assign payload_len  = res_head.payload_len;
  assign crc_ok       = res_head.crc_ok;
  assign last         = res_head.last;

endmodule

>>> tb/tb_crc16_frame_deframer_top.sv
// Self-checking testbench for crc16_frame_deframer_top: byte stream in, payload and status out.
// Depends on cfd_pkg and the deframer RTL; predicts every result with its own frame parser.
module tb_crc16_frame_deframer_top;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 16;
  localparam int MaxPrinted   = 100;

  // Frame parser phases of the predictor
  typedef enum logic [3:0] {
    ST_HUNT, ST_ADDR_LO, ST_ADDR_HI, ST_TYPE, ST_CMD,
    ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CRC_LO, ST_CRC_HI
  } parse_phase_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] frame_addr;
  logic [7:0]  frame_type;
  logic [7:0]  frame_cmd;
  logic [15:0] payload_len;
  logic        crc_ok;
  logic        last;

  // Register copies and parser state of the predictor
  logic [7:0]   hdr_first  = cfd_pkg::HeaderFirstRst;
  logic [7:0]   hdr_second = cfd_pkg::HeaderSecondRst;
  logic [15:0]  max_frame  = cfd_pkg::MaxFrameRst;
  parse_phase_t ph         = ST_HUNT;
  bit           armed      = 1'b0;
  logic [15:0]  remaining  = '0;
  logic [15:0]  addr_q     = '0;
  logic [7:0]   type_q     = '0;
  logic [7:0]   cmd_q      = '0;
  logic [15:0]  len_q      = '0;
  logic [15:0]  crc_q      = cfd_pkg::CrcInit;
  logic [7:0]   crc_lo_q   = '0;
  logic [7:0]   rescan_buf [cfd_pkg::ReplayDepth];

  cfd_pkg::result_t pending_frame_results[$];
  logic [7:0]       frame_bytes[$];
  cfd_pkg::result_t got_result;
  cfd_pkg::result_t want_result;

  bit gaps_on = 1'b1;
  int error_count      = 0;
  int cycle_count      = 0;
  int bytes_sent       = 0;
  int framed_bytes     = 0;
  int results_checked  = 0;
  int payload_results  = 0;
  int frames_crc_good  = 0;
  int frames_crc_bad   = 0;
  int length_rejects   = 0;
  int settings_written = 0;

  crc16_frame_deframer_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .payload_byte(payload_byte), .frame_addr(frame_addr),
    .frame_type(frame_type), .frame_cmd(frame_cmd), .payload_len(payload_len),
    .crc_ok(crc_ok), .last(last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_frame_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Print and count one mismatch
  task automatic log_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (result %0d)",
                             name, got, want, results_checked));
  endtask

  // Modbus CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ cfd_pkg::CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic cfd_pkg::result_t frame_result(input logic k, input logic [7:0] pb,
                                                    input logic ok);
    cfd_pkg::result_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.frame_addr   = addr_q;
    r.frame_type   = type_q;
    r.frame_cmd    = cmd_q;
    r.payload_len  = len_q;
    r.crc_ok       = ok;
    r.last         = k;
    return r;
  endfunction

  // Advance the predicted parser by one byte; flag an oversize length
  task automatic parse_byte(input logic [7:0] b, output bit rejected);
    rejected = 1'b0;
    case (ph)
      ST_ADDR_LO: begin
        rescan_buf[0] = b;
        addr_q = {8'h00, b};
        ph = ST_ADDR_HI;
      end
      ST_ADDR_HI: begin
        rescan_buf[1] = b;
        addr_q[15:8] = b;
        ph = ST_TYPE;
      end
      ST_TYPE: begin
        rescan_buf[2] = b;
        type_q = b;
        crc_q = crc16_next(crc_q, b);
        ph = ST_CMD;
      end
      ST_CMD: begin
        rescan_buf[3] = b;
        cmd_q = b;
        crc_q = crc16_next(crc_q, b);
        ph = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        rescan_buf[4] = b;
        len_q = {8'h00, b};
        crc_q = crc16_next(crc_q, b);
        ph = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        rescan_buf[5] = b;
        len_q[15:8] = b;
        crc_q = crc16_next(crc_q, b);
        if ({1'b0, len_q} + cfd_pkg::FrameOverhead > {1'b0, max_frame}) begin
          ph = ST_HUNT;
          armed = 1'b0;
          rejected = 1'b1;
        end else begin
          remaining = len_q;
          ph = (len_q == 16'd0) ? ST_CRC_LO : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        crc_q = crc16_next(crc_q, b);
        remaining = remaining - 16'd1;
        if (remaining == 16'd0)
          ph = ST_CRC_LO;
        pending_frame_results.push_back(frame_result(1'b0, b, 1'b0));
        payload_results++;
      end
      ST_CRC_LO: begin
        crc_lo_q = b;
        ph = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        ph = ST_HUNT;
        armed = 1'b0;
        pending_frame_results.push_back(frame_result(1'b1, 8'h00, {b, crc_lo_q} == crc_q));
        if ({b, crc_lo_q} == crc_q) frames_crc_good++;
        else frames_crc_bad++;
      end
      default: begin
        ph = ST_HUNT;
        if (armed && b == hdr_second) begin
          armed = 1'b0;
          crc_q = cfd_pkg::CrcInit;
          remaining = '0;
          ph = ST_ADDR_LO;
        end else begin
          armed = (b == hdr_first);
        end
      end
    endcase
  endtask

  // Predict one accepted byte, including the rescan after a rejected length
  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] replay [cfd_pkg::ReplayDepth];
    bit rej;
    bit unused;
    if (ph != ST_HUNT)
      framed_bytes++;
    parse_byte(b, rej);
    if (rej) begin
      length_rejects++;
      replay = rescan_buf;
      foreach (replay[i])
        parse_byte(replay[i], unused);
    end
  endtask

  // Drive one byte transaction and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes(input int count);
    for (int i = 0; i < count; i++)
      send_byte(frame_bytes[i]);
  endtask

  // Assemble a frame; an oversize one ends a few bytes after its length field
  task automatic build_frame(input logic [15:0] addr, input logic [7:0] ftype,
                             input logic [7:0] fcmd, input logic [15:0] len,
                             input bit bad_crc, input bit oversize);
    logic [15:0] crc;
    logic [7:0]  pb;
    int          n;
    frame_bytes = {};
    crc = cfd_pkg::CrcInit;
    frame_bytes.push_back(hdr_first);
    frame_bytes.push_back(hdr_second);
    frame_bytes.push_back(addr[7:0]);
    frame_bytes.push_back(addr[15:8]);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(fcmd);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    crc = crc16_next(crc, ftype);
    crc = crc16_next(crc, fcmd);
    crc = crc16_next(crc, len[7:0]);
    crc = crc16_next(crc, len[15:8]);
    n = oversize ? $urandom_range(0, 4) : int'(len);
    for (int i = 0; i < n; i++) begin
      pb = 8'($urandom_range(0, 255));
      frame_bytes.push_back(pb);
      crc = crc16_next(crc, pb);
    end
    if (!oversize) begin
      if (bad_crc)
        crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
    end
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hdr_first);
    return b;
  endfunction

  // Bring the parser back to an unarmed hunt; zero lengths keep stray frames short
  task automatic resync();
    while (ph != ST_HUNT || armed)
      send_byte((ph == ST_LEN_LO || ph == ST_LEN_HI) ? 8'h00 : noise_byte());
  endtask

  // Wait for all results, then let a pending rescan finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frame_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_write(input cfd_pkg::reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input cfd_pkg::reg_idx_t idx, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read back a register and compare at its own width
  task automatic check_reg(input cfd_pkg::reg_idx_t idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_read(idx, rd);
    if (idx == cfd_pkg::REG_MAX_FRAME)
      compare_field(idx.name(), rd[15:0], want[15:0]);
    else
      compare_field(idx.name(), {8'h00, rd[7:0]}, {8'h00, want[7:0]});
  endtask

  task automatic write_reg(input cfd_pkg::reg_idx_t idx, input logic [31:0] value);
    settle();
    apb_write(idx, value);
    case (idx)
      cfd_pkg::REG_HEADER_FIRST:  hdr_first  = value[7:0];
      cfd_pkg::REG_HEADER_SECOND: hdr_second = value[7:0];
      cfd_pkg::REG_MAX_FRAME:     max_frame  = value[15:0];
      default: ;
    endcase
    settings_written++;
    check_reg(idx, value);
  endtask

  task automatic pick_settings(input int max_hi);
    write_reg(cfd_pkg::REG_HEADER_FIRST, $urandom_range(0, 255));
    write_reg(cfd_pkg::REG_HEADER_SECOND, $urandom_range(0, 255));
    write_reg(cfd_pkg::REG_MAX_FRAME, $urandom_range(10, max_hi));
  endtask

  // Mostly well-formed frames with random content, plus oversize, cut-off and noise
  task automatic random_traffic(input int n, input bit idle);
    int          stop_at;
    int          pick;
    int          lim;
    int          k;
    logic [15:0] room;
    logic [15:0] len;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      gaps_on = idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // line noise, sometimes arming on the first header byte
        repeat ($urandom_range(1, 4))
          send_byte($urandom_range(0, 3) == 0 ? hdr_first : 8'($urandom_range(0, 255)));
      end else begin
        resync();
        room = max_frame - 16'd10;
        if (room <= 16'd40 && $urandom_range(0, 5) == 0)
          len = room;
        else
          len = 16'($urandom_range(0, room < 16'd12 ? int'(room) : 12));
        if (pick < 70) begin
          build_frame(16'($urandom), 8'($urandom), 8'($urandom), len,
                      $urandom_range(0, 4) == 0, 1'b0);
          send_frame_bytes(frame_bytes.size());
        end else if (pick < 85) begin
          // length just past the limit; sometimes hide a header pair in the rescan
          lim = 65535 - (int'(max_frame) - 9);
          if (lim > 20) lim = 20;
          len = max_frame - 16'd9 + 16'($urandom_range(0, lim));
          build_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b0, 1'b1);
          if ($urandom_range(0, 2) == 0) begin
            k = $urandom_range(2, 4);
            frame_bytes[k]     = hdr_first;
            frame_bytes[k + 1] = hdr_second;
            // zero the tail so a length read after the rescan stays short
            for (int i = 8; i < frame_bytes.size(); i++)
              frame_bytes[i] = 8'h00;
          end
          send_frame_bytes(frame_bytes.size());
        end else if (pick < 95) begin
          build_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
          send_frame_bytes($urandom_range(1, frame_bytes.size() - 1));
        end else begin
          // repeated first header byte ahead of a frame
          if (max_frame <= 16'd300)
            repeat ($urandom_range(1, 2)) send_byte(hdr_first);
          build_frame(16'($urandom), 8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
          send_frame_bytes(frame_bytes.size());
        end
      end
    end
  endtask

  task automatic test_register_reset();
    check_reg(cfd_pkg::REG_HEADER_FIRST, {24'h0, cfd_pkg::HeaderFirstRst});
    check_reg(cfd_pkg::REG_HEADER_SECOND, {24'h0, cfd_pkg::HeaderSecondRst});
    check_reg(cfd_pkg::REG_MAX_FRAME, {16'h0, cfd_pkg::MaxFrameRst});
  endtask

  task automatic test_directed_frames();
    logic [15:0] over_len;
    logic [15:0] bad_crc;
    gaps_on = 1'b1;
    // re-arm on a repeated first header byte, then a zero-length frame with extreme fields
    send_byte(hdr_first);
    build_frame(16'hFFFF, 8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);
    send_frame_bytes(frame_bytes.size());
    // length one past the limit: drop the header, the rescan finds a header pair
    over_len = max_frame - 16'd9;
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(over_len[7:0]);
    send_byte(over_len[15:8]);
    // rescanned frame now sits at its length field: one payload byte, corrupt CRC
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    bad_crc = crc_q ^ 16'h0001;
    send_byte(bad_crc[7:0]);
    send_byte(bad_crc[15:8]);
  endtask

  task automatic test_default_traffic();
    random_traffic(300, 1'b1);
  endtask

  task automatic test_header_extremes();
    // equal all-zero headers, smallest frame limit
    write_reg(cfd_pkg::REG_HEADER_FIRST, 32'h00);
    write_reg(cfd_pkg::REG_HEADER_SECOND, 32'h00);
    write_reg(cfd_pkg::REG_MAX_FRAME, 32'd10);
    random_traffic(200, 1'b1);
    // all-ones first header, largest frame limit
    write_reg(cfd_pkg::REG_HEADER_FIRST, 32'hFF);
    write_reg(cfd_pkg::REG_MAX_FRAME, 32'd65535);
    random_traffic(250, 1'b1);
    // all-ones second header, tight limit
    write_reg(cfd_pkg::REG_HEADER_FIRST, $urandom_range(0, 255));
    write_reg(cfd_pkg::REG_HEADER_SECOND, 32'hFF);
    write_reg(cfd_pkg::REG_MAX_FRAME, $urandom_range(11, 40));
    random_traffic(200, 1'b1);
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      pick_settings(80);
      random_traffic(60, 1'b1);
    end
  endtask

  task automatic test_steady_stream();
    pick_settings(60);
    random_traffic(300, 1'b0);
  endtask

  // Output stall bursts
  initial begin : out_stall_gen
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result = '{kind, payload_byte, frame_addr, frame_type, frame_cmd,
                     payload_len, crc_ok, last};
      if (pending_frame_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result: kind %0b byte 0x%0h addr 0x%0h",
                               kind, payload_byte, frame_addr));
      end else begin
        want_result = pending_frame_results.pop_front();
        compare_field("kind", 16'(got_result.kind), 16'(want_result.kind));
        compare_field("payload_byte", 16'(got_result.payload_byte),
                      16'(want_result.payload_byte));
        compare_field("frame_addr", got_result.frame_addr, want_result.frame_addr);
        compare_field("frame_type", 16'(got_result.frame_type),
                      16'(want_result.frame_type));
        compare_field("frame_cmd", 16'(got_result.frame_cmd),
                      16'(want_result.frame_cmd));
        compare_field("payload_len", got_result.payload_len, want_result.payload_len);
        compare_field("crc_ok", 16'(got_result.crc_ok), 16'(want_result.crc_ok));
        compare_field("last", 16'(got_result.last), 16'(want_result.last));
      end
      results_checked++;
    end
  end

  // Test sequence
  initial begin
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_directed_frames();
    test_default_traffic();
    test_header_extremes();
    test_random_settings();
    test_steady_stream();
    settle();

    $display("Sent %0d bytes (%0d inside frames) over %0d register writes; %0d oversize drops.",
             bytes_sent, framed_bytes, settings_written, length_rejects);
    $display("Checked %0d results: %0d payload bytes, %0d good-CRC and %0d bad-CRC frame ends.",
             results_checked, payload_results, frames_crc_good, frames_crc_bad);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cfd_pkg.sv
sv/cfd_ctrl.sv
sv/cfd_datapath.sv
sv/crc16_frame_deframer_top.sv
tb/tb_crc16_frame_deframer_top.sv
